>>> rtl/core/hbt_pkg.sv
// hbt_pkg: shared types and constants of the hue blob tracker.
// Holds the register map, the configuration and result records.
// No dependencies; imported by every module of the block but hbt_queue.
package hbt_pkg;

    localparam int unsigned PIX_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 21;
    localparam int unsigned AREA_W     = 21;
    localparam int unsigned SUM_W      = 30;
    localparam int unsigned TDATA_W    = 88;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VAL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_HUE_MAX      = 8'd179;
    localparam logic [20:0] RST_AREA_MIN     = 21'd1;
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd240;

    // colour conversion constants
    localparam logic [7:0] SAT_SCALE = 8'd255;
    localparam logic [7:0] HUE_SCALE = 8'd30;
    localparam logic [7:0] HUE_BASE_G = 8'd60;
    localparam logic [7:0] HUE_BASE_B = 8'd120;
    localparam logic [7:0] HUE_WRAP   = 8'd180;

    localparam logic [AREA_W-1:0] COUNT_CAP = '1;
    localparam logic [9:0]        CENTRE_CAP = '1;

    typedef struct packed {
        logic [7:0]  hue_min;
        logic [7:0]  hue_max;
        logic [7:0]  min_sat;
        logic [7:0]  min_val;
        logic [20:0] area_min;
        logic [10:0] frame_width;
        logic [10:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic        status;
        logic [9:0]  centroid_x;
        logic [9:0]  centroid_y;
        logic [10:0] box_left;
        logic [10:0] box_top;
        logic [9:0]  box_right;
        logic [9:0]  box_bottom;
        logic [20:0] area;
    } result_t;

endpackage

>>> rtl/core/hbt_queue.sv
// hbt_queue: small FIFO of classified pixels between front and back.
// Depends on nothing but its parameters.
module hbt_queue #(
    parameter int unsigned W     = 24,
    parameter int unsigned DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] pop_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    mem [DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [CNTW-1:0] count_reg;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rptr_reg];

    // store entries
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wptr_reg] <= push_data;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push && !full) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop && valid) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNTW'(push && !full) - CNTW'(pop && valid);
        end
    end

endmodule

>>> rtl/core/hbt_front.sv
// hbt_front: accepts RGB565 pixels, tracks raster position and classifies
// each pixel against the colour window. Uses hbt_pkg; feeds hbt_queue.
module hbt_front
    import hbt_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cfg_t                            cfg,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  logic [PIX_W-1:0]                pix_word,
    input  logic                            pix_last,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [2+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned EWC = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int unsigned EWR = (RW + 1 > 11) ? RW + 1 : 11;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PIX_W-1:0] pix_reg;
    logic             last_reg;
    logic [CW-1:0]    col_reg, x_reg;
    logic [RW-1:0]    row_reg, y_reg;
    logic [3:0]       step_reg;
    logic [15:0]      sn_reg, hn_reg;
    logic [7:0]       srem_reg, hrem_reg;
    logic [7:0]       sd_reg, hd_reg;
    logic             neg_reg, zero_reg;
    logic [7:0]       base_reg;

    logic [7:0]  r, g, b, hi, lo, delta, mag, base;
    logic [8:0]  diff;
    logic        neg;
    logic [8:0]  strial, htrial;
    logic [7:0]  sat, hue, hq;
    logic        hue_ok, match;
    logic [EWC-1:0] cinc;
    logic [EWR-1:0] rinc;

    // widen to 8-bit RGB, find max, min and the hue sector
    always_comb begin
        r = {pix_reg[15:11], 3'b000};
        g = {pix_reg[10:5], 2'b00};
        b = {pix_reg[4:0], 3'b000};
        hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        delta = hi - lo;
        if (hi == r) begin
            diff = {1'b0, g} - {1'b0, b};
            base = '0;
        end else if (hi == g) begin
            diff = {1'b0, b} - {1'b0, r};
            base = HUE_BASE_G;
        end else begin
            diff = {1'b0, r} - {1'b0, g};
            base = HUE_BASE_B;
        end
        neg = diff[8];
        mag = neg ? 8'(-diff) : diff[7:0];
    end

    // one restoring step of both dividers
    assign strial = {srem_reg, sn_reg[15]};
    assign htrial = {hrem_reg, hn_reg[15]};

    // finish hue and test the colour window
    always_comb begin
        hq  = {3'b000, hn_reg[4:0]};
        sat = zero_reg ? '0 : sn_reg[7:0];
        if (zero_reg) begin
            hue = '0;
        end else if (!neg_reg) begin
            hue = base_reg + hq;
        end else if (base_reg >= hq) begin
            hue = base_reg - hq;
        end else begin
            hue = base_reg + HUE_WRAP - hq;
        end
        if (cfg.hue_min > cfg.hue_max) begin
            hue_ok = (hue >= cfg.hue_min) || (hue <= cfg.hue_max);
        end else begin
            hue_ok = (hue >= cfg.hue_min) && (hue <= cfg.hue_max);
        end
        match = (sat >= cfg.min_sat) && (sd_reg >= cfg.min_val) && hue_ok;
    end

    assign pix_ready = (state_reg == ST_IDLE);
    assign q_push    = (state_reg == ST_PUSH) && !q_full;
    assign q_data    = {match, last_reg, x_reg, y_reg};

    assign cinc = EWC'(col_reg) + 1'b1;
    assign rinc = EWR'(row_reg) + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pix_valid) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (step_reg == '1) state_next = ST_PUSH;
            ST_PUSH: if (!q_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control: state and raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (pix_valid && pix_ready) begin
                if (pix_last) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (cinc >= EWC'(cfg.frame_width) || cinc >= EWC'(MAX_WIDTH)) begin
                    col_reg <= '0;
                    row_reg <= (rinc >= EWR'(MAX_HEIGHT)) ? '0 : RW'(rinc);
                end else begin
                    col_reg <= CW'(cinc);
                end
            end
        end
    end

    // datapath: capture, load and iterate the dividers
    always_ff @(posedge aclk) begin
        if (pix_valid && pix_ready) begin
            pix_reg  <= pix_word;
            last_reg <= pix_last;
            x_reg    <= col_reg;
            y_reg    <= row_reg;
        end
        if (state_reg == ST_LOAD) begin
            sn_reg   <= 16'(delta) * 16'(SAT_SCALE);
            hn_reg   <= 16'(mag) * 16'(HUE_SCALE);
            srem_reg <= '0;
            hrem_reg <= '0;
            sd_reg   <= hi;
            hd_reg   <= delta;
            neg_reg  <= neg;
            base_reg <= base;
            zero_reg <= (delta == '0);
            step_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            step_reg <= step_reg + 1'b1;
            if (strial >= {1'b0, sd_reg}) begin
                srem_reg <= 8'(strial - {1'b0, sd_reg});
                sn_reg   <= {sn_reg[14:0], 1'b1};
            end else begin
                srem_reg <= strial[7:0];
                sn_reg   <= {sn_reg[14:0], 1'b0};
            end
            if (htrial >= {1'b0, hd_reg}) begin
                hrem_reg <= 8'(htrial - {1'b0, hd_reg});
                hn_reg   <= {hn_reg[14:0], 1'b1};
            end else begin
                hrem_reg <= htrial[7:0];
                hn_reg   <= {hn_reg[14:0], 1'b0};
            end
        end
    end

endmodule

>>> rtl/core/hbt_back.sv
// hbt_back: accumulates matching pixels and, at the end of a frame, divides
// the coordinate sums into the centroid. Uses hbt_pkg; reads hbt_queue.
module hbt_back
    import hbt_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  cfg_wr_t cfg_wr,
    input  logic    q_valid,
    input  logic [2+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_data,
    output logic    q_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned EWC = (CW > 11) ? CW : 11;
    localparam int unsigned EWR = (RW > 11) ? RW : 11;

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [SUM_W-1:0]  sumx_reg, sumy_reg, nx_reg, ny_reg;
    logic [AREA_W-1:0] cnt_reg, rx_reg, ry_reg;
    logic [10:0]       lcol_reg, lrow_reg;
    logic [CW-1:0]     gcol_reg;
    logic [RW-1:0]     grow_reg;
    logic [4:0]        step_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    logic          q_match, q_last;
    logic [CW-1:0] q_x;
    logic [RW-1:0] q_y;
    logic [SUM_W:0]  sx, sy;
    logic [SUM_W-1:0] sx_sat, sy_sat;
    logic            add_en;
    logic [AREA_W:0] tx, ty;
    logic [9:0]      cx, cy;
    result_t         out_next;

    assign {q_match, q_last, q_x, q_y} = q_data;
    assign q_pop = q_valid && (state_reg == ST_ACC) && (!q_last || !out_valid_reg);
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    assign sx = {1'b0, sumx_reg} + (SUM_W + 1)'(q_x);
    assign sy = {1'b0, sumy_reg} + (SUM_W + 1)'(q_y);
    assign sx_sat = sx[SUM_W] ? '1 : sx[SUM_W-1:0];
    assign sy_sat = sy[SUM_W] ? '1 : sy[SUM_W-1:0];
    assign add_en = q_pop && q_match && (cnt_reg != COUNT_CAP);
    assign tx = {rx_reg, nx_reg[SUM_W-1]};
    assign ty = {ry_reg, ny_reg[SUM_W-1]};
    assign cx = (cnt_reg == '0) ? '0 : ((|nx_reg[SUM_W-1:10]) ? CENTRE_CAP : nx_reg[9:0]);
    assign cy = (cnt_reg == '0) ? '0 : ((|ny_reg[SUM_W-1:10]) ? CENTRE_CAP : ny_reg[9:0]);

    // build the result word: all zero but the status when too small
    always_comb begin
        out_next = '0;
        if (cnt_reg < cfg.area_min) begin
            out_next.status = 1'b1;
        end else begin
            out_next.centroid_x = cx;
            out_next.centroid_y = cy;
            out_next.box_left   = lcol_reg;
            out_next.box_top    = lrow_reg;
            out_next.box_right  = 10'(gcol_reg);
            out_next.box_bottom = 10'(grow_reg);
            out_next.area       = cnt_reg;
        end
    end

    // control: frame state, sequencing and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
            sumx_reg      <= '0;
            sumy_reg      <= '0;
            cnt_reg       <= '0;
            lcol_reg      <= RST_FRAME_WIDTH;
            lrow_reg      <= RST_FRAME_HEIGHT;
            gcol_reg      <= '0;
            grow_reg      <= '0;
        end else begin
            if (out_valid_reg && res_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_ACC: begin
                    if (q_pop) begin
                        if (q_match) begin
                            if (cnt_reg != COUNT_CAP) begin
                                cnt_reg  <= cnt_reg + 1'b1;
                                sumx_reg <= sx_sat;
                                sumy_reg <= sy_sat;
                            end
                            if (EWC'(q_x) < EWC'(lcol_reg)) lcol_reg <= 11'(q_x);
                            if (EWR'(q_y) < EWR'(lrow_reg)) lrow_reg <= 11'(q_y);
                            if (q_x > gcol_reg) gcol_reg <= q_x;
                            if (q_y > grow_reg) grow_reg <= q_y;
                        end
                        if (q_last) state_reg <= ST_DIV;
                    end
                    // reload the box start while nothing has matched
                    if (cfg_wr.we && cnt_reg == '0) begin
                        if (cfg_wr.idx == CFG_FRAME_WIDTH)  lcol_reg <= cfg_wr.data[10:0];
                        if (cfg_wr.idx == CFG_FRAME_HEIGHT) lrow_reg <= cfg_wr.data[10:0];
                    end
                end
                ST_DIV: begin
                    if (step_reg == 5'(SUM_W - 1)) state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_ACC;
                    sumx_reg      <= '0;
                    sumy_reg      <= '0;
                    cnt_reg       <= '0;
                    lcol_reg      <= cfg.frame_width;
                    lrow_reg      <= cfg.frame_height;
                    gcol_reg      <= '0;
                    grow_reg      <= '0;
                end
                default: state_reg <= ST_ACC;
            endcase
        end
    end

    // datapath: centroid dividers and result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACC) begin
            // take the sums including the word popped this cycle
            nx_reg   <= add_en ? sx_sat : sumx_reg;
            ny_reg   <= add_en ? sy_sat : sumy_reg;
            rx_reg   <= '0;
            ry_reg   <= '0;
            step_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            step_reg <= step_reg + 1'b1;
            if (tx >= {1'b0, cnt_reg}) begin
                rx_reg <= AREA_W'(tx - {1'b0, cnt_reg});
                nx_reg <= {nx_reg[SUM_W-2:0], 1'b1};
            end else begin
                rx_reg <= tx[AREA_W-1:0];
                nx_reg <= {nx_reg[SUM_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, cnt_reg}) begin
                ry_reg <= AREA_W'(ty - {1'b0, cnt_reg});
                ny_reg <= {ny_reg[SUM_W-2:0], 1'b1};
            end else begin
                ry_reg <= ty[AREA_W-1:0];
                ny_reg <= {ny_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_DONE) begin
            out_reg <= out_next;
        end
    end

    // no pixel is taken while the centroid is being divided
    a_no_pop_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ACC) |-> !q_pop)
        else $error("pixel taken during centroid division");

    // a finished frame publishes a result and leaves clear accumulators
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> (out_valid_reg && cnt_reg == '0 && sumx_reg == '0))
        else $error("frame end did not clear accumulators");

    // sums only grow together with the count
    a_sums_follow_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (sumx_reg == '0 && sumy_reg == '0))
        else $error("coordinate sum without matching pixels");

    // a last pixel never overtakes an unread result
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_last) |-> !out_valid_reg)
        else $error("frame closed while a result is still pending");

endmodule

>>> rtl/core/hue_blob_tracker_unit.sv
// hue_blob_tracker_unit: colour blob centroid and bounding box tracker.
// Uses hbt_pkg, hbt_front, hbt_queue and hbt_back.
//
// Usage:
//   Pixels enter on the s_ stream in raster order, one RGB565 word per item;
//   s_tlast marks the final pixel of a frame. The cfg_ port writes the
//   colour window, minimum area and frame size between frames.
//   One result per frame leaves on the m_ stream: m_tuser is the status
//   (0 found, 1 not found) and m_tdata the centroid, box and area.
// Pacing: the front takes a new pixel only after the previous one has been
//   captured, loaded into its saturation and hue dividers (one bit per cycle
//   over 16 steps) and pushed into the queue, so it can stall on a full queue.
// Result: once the back takes the last pixel from the four-entry queue, the
//   centroid dividers run 30 steps, then a publish state sets the result valid.
// Stall: a waiting result sits in the output register; the back keeps
//   accumulating the next frame and holds only its last pixel until the
//   result is taken, and the queue then fills and stops the front.
// Reset: registers return to their defaults and accumulators clear at once;
//   the block accepts pixels in the first cycle after reset.
module hue_blob_tracker_unit
    import hbt_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel_word
    input  logic                  s_tlast,   // last_pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] centroid_x, [19:10] centroid_y, [30:20] box_left, [41:31] box_top,
    // [51:42] box_right, [61:52] box_bottom, [82:62] area, [87:83] zero
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tuser    // status
);

    localparam int unsigned QW = 2 + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

    cfg_t    cfg_reg;
    cfg_wr_t cfg_wr;
    result_t res;
    logic          q_push, q_full, q_pop, q_valid;
    logic [QW-1:0] q_in, q_out;

    assign cfg_wr = '{we: cfg_we, idx: cfg_addr, data: cfg_wdata};

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hue_min      <= '0;
            cfg_reg.hue_max      <= RST_HUE_MAX;
            cfg_reg.min_sat      <= '0;
            cfg_reg.min_val      <= '0;
            cfg_reg.area_min     <= RST_AREA_MIN;
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HUE_MIN:      cfg_reg.hue_min      <= cfg_wdata[7:0];
                CFG_HUE_MAX:      cfg_reg.hue_max      <= cfg_wdata[7:0];
                CFG_MIN_SAT:      cfg_reg.min_sat      <= cfg_wdata[7:0];
                CFG_MIN_VAL:      cfg_reg.min_val      <= cfg_wdata[7:0];
                CFG_AREA_MIN:     cfg_reg.area_min     <= cfg_wdata[20:0];
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[10:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    hbt_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .pix_valid(s_tvalid),
        .pix_ready(s_tready),
        .pix_word (s_tdata),
        .pix_last (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    hbt_queue #(
        .W    (QW),
        .DEPTH(4)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_out)
    );

    hbt_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cfg_wr   (cfg_wr),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .res      (res)
    );

    // pack the result word
    assign m_tuser = res.status;
    assign m_tdata = {5'b0, res.area, res.box_bottom, res.box_right, res.box_top,
                      res.box_left, res.centroid_y, res.centroid_x};

endmodule

>>> verif/hue_blob_tracker_unit_tb.sv
// Testbench for hue_blob_tracker_unit: RGB565 frames in, one blob record per frame out.
// Depends on hbt_pkg and the RTL of the block; a built-in predictor supplies the expected records.
`timescale 1ns / 1ps

module hue_blob_tracker_unit_tb;
    import hbt_pkg::*;

    localparam int unsigned MAX_W = 1024;
    localparam int unsigned MAX_H = 1024;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYCLES = 200;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;

    hue_blob_tracker_unit #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (.*);

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register copy
    logic [7:0]  hue_lo, hue_hi, sat_floor, val_floor;
    logic [20:0] area_floor;
    logic [10:0] width_reg, height_reg;
    // frame accumulation copy
    logic [9:0]  col_pos, row_pos;
    logic [29:0] col_sum, row_sum;
    logic [20:0] hits;
    logic [10:0] min_col, min_row;
    logic [9:0]  max_col, max_row;

    result_t blob_records[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_hold = 0;
    bit          no_gaps = 1'b0;

    task automatic report(string what, int unsigned got, int unsigned want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic void clear_frame();
        col_pos = '0; row_pos = '0; col_sum = '0; row_sum = '0; hits = '0;
        min_col = width_reg; min_row = height_reg; max_col = '0; max_row = '0;
    endfunction

    function automatic bit colour_hit(logic [15:0] w);
        int r, g, b, lo, hi, delta, sat, hue;
        r = (w & 16'hF800) >> 8;
        g = (w & 16'h07E0) >> 3;
        b = (w & 16'h001F) << 3;
        lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        delta = hi - lo;
        sat = 0;
        hue = 0;
        if (hi != 0 && delta != 0) begin
            sat = (delta * 255) / hi;
            if (hi == r) hue = (30 * (g - b)) / delta;
            else if (hi == g) hue = 60 + (30 * (b - r)) / delta;
            else hue = 120 + (30 * (r - g)) / delta;
            if (hue < 0) hue += 180;
            if (hue >= 180) hue -= 180;
        end
        if (sat < sat_floor || hi < val_floor) return 1'b0;
        if (hue_lo > hue_hi) return hue >= hue_lo || hue <= hue_hi;
        return hue >= hue_lo && hue <= hue_hi;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [20:0] val);
        case (idx)
            CFG_HUE_MIN:  hue_lo = val[7:0];
            CFG_HUE_MAX:  hue_hi = val[7:0];
            CFG_MIN_SAT:  sat_floor = val[7:0];
            CFG_MIN_VAL:  val_floor = val[7:0];
            CFG_AREA_MIN: area_floor = val;
            CFG_FRAME_WIDTH: begin
                width_reg = val[10:0];
                if (hits == 0) min_col = width_reg;
            end
            CFG_FRAME_HEIGHT: begin
                height_reg = val[10:0];
                if (hits == 0) min_row = height_reg;
            end
            default: ;
        endcase
    endfunction

    // advance the frame by one pixel; queue a record on the last one
    function automatic void track_pixel(logic [15:0] w, logic last);
        int unsigned x, y, nx, cx, cy;
        result_t rec;
        x = col_pos;
        y = row_pos;
        if (colour_hit(w)) begin
            if (hits != COUNT_CAP) begin
                hits++;
                col_sum = (30'h3FFFFFFF - col_sum < x) ? 30'h3FFFFFFF : col_sum + x;
                row_sum = (30'h3FFFFFFF - row_sum < y) ? 30'h3FFFFFFF : row_sum + y;
            end
            if (x < min_col) min_col = x;
            if (y < min_row) min_row = y;
            if (x > max_col) max_col = x;
            if (y > max_row) max_row = y;
        end
        nx = x + 1;
        if (nx >= width_reg || nx >= MAX_W) begin
            col_pos = '0;
            row_pos = (y + 1 >= MAX_H) ? '0 : y + 1;
        end else begin
            col_pos = nx;
        end
        if (!last) return;
        rec = '0;
        if (hits < area_floor) begin
            rec.status = 1'b1;
        end else begin
            cx = (hits != 0) ? col_sum / hits : 0;
            cy = (hits != 0) ? row_sum / hits : 0;
            rec.centroid_x = (cx > 1023) ? 10'd1023 : cx;
            rec.centroid_y = (cy > 1023) ? 10'd1023 : cy;
            rec.box_left = min_col;
            rec.box_top = min_row;
            rec.box_right = max_col;
            rec.box_bottom = max_row;
            rec.area = hits;
        end
        blob_records.push_back(rec);
        clear_frame();
    endfunction

    // watch both channels and the register port at each rising edge
    always @(posedge aclk) begin
        result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else if (aresetn) begin
            if (cfg_we) apply_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready) track_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (blob_records.size() == 0) begin
                    report("unexpected word", 1, 0);
                end else begin
                    want = blob_records.pop_front();
                    if (m_tuser !== want.status) report("status", m_tuser, want.status);
                    if (m_tdata[9:0] !== want.centroid_x)
                        report("centroid_x", m_tdata[9:0], want.centroid_x);
                    if (m_tdata[19:10] !== want.centroid_y)
                        report("centroid_y", m_tdata[19:10], want.centroid_y);
                    if (m_tdata[30:20] !== want.box_left)
                        report("box_left", m_tdata[30:20], want.box_left);
                    if (m_tdata[41:31] !== want.box_top)
                        report("box_top", m_tdata[41:31], want.box_top);
                    if (m_tdata[51:42] !== want.box_right)
                        report("box_right", m_tdata[51:42], want.box_right);
                    if (m_tdata[61:52] !== want.box_bottom)
                        report("box_bottom", m_tdata[61:52], want.box_bottom);
                    if (m_tdata[82:62] !== want.area)
                        report("area", m_tdata[82:62], want.area);
                end
                rx_stall = no_gaps ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // receiver: long hold-off first, then per-word stall
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one pixel word, wait for it to be taken, then idle a while
    task automatic send_pixel(logic [15:0] w, logic last);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_frame(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_pixel($urandom(), i == len - 1);
    endtask

    // drain all records and let the pipeline settle before touching registers
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (blob_records.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_regs(logic [20:0] hmin, logic [20:0] hmax, logic [20:0] smin,
                             logic [20:0] vmin, logic [20:0] amin, logic [20:0] wid,
                             logic [20:0] hgt);
        logic [20:0] vals[7];
        vals = '{hmin, hmax, smin, vmin, amin, wid, hgt};
        settle();
        for (int i = 0; i < 7; i++) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_addr <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // single pixels of pure colours under default and narrowed windows
    task automatic test_directed();
        send_pixel(16'hF800, 1'b1);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h07E0, 1'b1);
        // nothing matches, yet the blob is reported with the start box
        load_regs(0, 179, 255, 255, 0, 320, 240);
        send_pixel(16'h8410, 1'b1);
        // area floor unreachable: not found
        load_regs(0, 179, 0, 0, 21'h1FFFFF, 320, 240);
        send_pixel(16'hF800, 1'b1);
        // wrapped hue window, zero width acts as one column
        load_regs(170, 10, 0, 0, 1, 0, 0);
        send_pixel(16'hF81F, 1'b0);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'h001F, 1'b0);
        send_pixel(16'hFFE0, 1'b0);
        send_pixel(16'hF810, 1'b1);
        // widths beyond the maximum, hue bounds above the scale
        load_regs(255, 255, 0, 0, 1, 2047, 2047);
        send_pixel(16'h07FF, 1'b0);
        send_pixel(16'hFC00, 1'b1);
        load_regs(0, 255, 0, 0, 1, 1024, 1024);
        send_pixel(16'h001F, 1'b0);
        send_pixel(16'hF800, 1'b1);
    endtask

    // row counter wraps at the height maximum with a one-column frame
    task automatic test_row_wrap();
        load_regs(0, 179, 0, 0, 1, 1, 1024);
        no_gaps = 1'b1;
        for (int unsigned i = 0; i < MAX_H + 6; i++)
            send_pixel((i >= MAX_H) ? 16'hF800 : 16'h001F, i == MAX_H + 5);
        no_gaps = 1'b0;
    endtask

    // random windows and sizes; one phase without gaps, one under back-pressure
    task automatic test_random(int unsigned budget);
        int unsigned sent, phase, len, wid;
        logic [20:0] amin;
        sent = 0;
        phase = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 7))
                0: wid = 0;
                1: wid = 1024;
                2: wid = 2047;
                default: wid = $urandom_range(1, 12);
            endcase
            amin = ($urandom_range(0, 9) == 0) ? 21'h1FFFFF : $urandom_range(0, 4);
            load_regs($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 179),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 179),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 80),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 80),
                      amin, wid, $urandom_range(0, 2047));
            no_gaps = (phase == 0);
            if (phase == 1) rx_hold = 800;
            repeat (8) begin
                // short frames while the receiver holds off, so results pile up
                len = (phase == 1) ? $urandom_range(1, 3) : $urandom_range(1, 24);
                send_frame(len);
                sent += len;
            end
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        hue_lo = '0; hue_hi = RST_HUE_MAX; sat_floor = '0; val_floor = '0;
        area_floor = RST_AREA_MIN; width_reg = RST_FRAME_WIDTH; height_reg = RST_FRAME_HEIGHT;
        clear_frame();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_row_wrap();
        test_random(250);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (blob_records.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
